/* rtl/gesture_tempo_estimator_top_defines.svh */
// Assertion macros for the gesture tempo estimator.
// Taken in by the top level only; it depends on nothing else.
`ifndef GESTURE_TEMPO_ESTIMATOR_TOP_DEFINES_SVH
`define GESTURE_TEMPO_ESTIMATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GTE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gesture tempo estimator check failed");

// Next-cycle implication, checked outside reset.
`define GTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gesture tempo estimator check failed");

`endif

/* rtl/gte_pkg.sv */
// Shared types and constants of the gesture tempo estimator.
// Used by the front end, the queue, the back end and the top level.
package gte_pkg;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_CHANGE_THRESHOLD = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MOTION_DEADBAND = 4'd1;

    localparam logic [15:0] CHANGE_THRESHOLD_RESET = 16'd25;
    localparam logic [7:0] MOTION_DEADBAND_RESET = 8'd1;

    localparam logic [31:0] BPM_NUMERATOR = 32'd60000;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [15:0] change_threshold;
        logic [7:0] motion_deadband;
    } cfg_t;

    typedef struct packed {
        logic beat_seen;
        logic do_average;
        logic [31:0] interval;
    } queue_entry_t;

endpackage

/* rtl/gte_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module gte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/gte_front.sv */
// Front end: accepts frames, detects direction reversals and queues the work.
// Depends on gte_pkg.
module gte_front #(
    parameter int SAMPLE_COUNT = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gte_pkg::cfg_t         cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [15:0]    hand_y,
    input  logic [31:0]           time_ms,
    input  logic                  active,
    input  logic                  queue_full,
    output logic                  push,
    output gte_pkg::queue_entry_t push_entry
);
    import gte_pkg::*;

    localparam int CNT_W = $clog2(SAMPLE_COUNT);
    localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(SAMPLE_COUNT - 1);

    logic signed [15:0] prev_y_reg;
    logic moving_down_reg;
    logic [31:0] last_time_reg;
    logic [CNT_W-1:0] count_reg;

    logic signed [16:0] step;
    logic signed [16:0] band_pos;
    logic signed [16:0] band_neg;
    logic reversal;
    logic beat;

    assign step = 17'(hand_y) - 17'(prev_y_reg);
    assign band_pos = $signed({9'b0, cfg.motion_deadband});
    assign band_neg = -band_pos;
    assign reversal = moving_down_reg ? (step > band_pos) : (step < band_neg);
    assign beat = active && reversal;

    assign in_ready = !queue_full;
    assign push = in_valid && in_ready;

    assign push_entry.beat_seen = beat;
    assign push_entry.do_average = beat && (count_reg == LAST_COUNT);
    assign push_entry.interval = time_ms - last_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_y_reg <= '0;
            moving_down_reg <= 1'b0;
            last_time_reg <= '0;
            count_reg <= '0;
        end
        else if (push && active)
        begin
            prev_y_reg <= hand_y;
            if (reversal)
            begin
                moving_down_reg <= !moving_down_reg;
                last_time_reg <= time_ms;
                count_reg <= (count_reg == LAST_COUNT) ? '0 : count_reg + 1'b1;
            end
        end
    end

endmodule

/* rtl/gte_queue.sv */
// Short FIFO that decouples the front end from the back end.
// Depends on gte_pkg.
module gte_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  gte_pkg::queue_entry_t push_entry,
    input  logic                  pop,
    output gte_pkg::queue_entry_t head,
    output logic                  full,
    output logic                  empty
);
    import gte_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

    queue_entry_t mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;

    assign head = mem_reg[rd_ptr_reg];
    assign full = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign empty = (fill_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/gte_div.sv */
// Serial restoring divider, one quotient bit per cycle, 32-bit divisor.
// No dependencies.
module gte_div #(
    parameter int WIDTH = 35
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [31:0]      divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic busy_reg;
    logic done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [WIDTH-1:0] quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] divisor_reg;

    logic [32:0] trial;
    logic [32:0] diff;
    logic fits;

    assign trial = {rem_reg, quo_reg[WIDTH-1]};
    assign diff = trial - {1'b0, divisor_reg};
    assign fits = (trial >= {1'b0, divisor_reg});

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[WIDTH-2:0], fits};
            rem_reg <= fits ? diff[31:0] : trial[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= CNT_W'(WIDTH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/gte_back.sv */
// Back end: stores intervals, computes the trimmed mean and tempo, drives results.
// Depends on gte_pkg, gte_ram and gte_div.
module gte_back #(
    parameter int SAMPLE_COUNT = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gte_pkg::cfg_t         cfg,
    input  gte_pkg::queue_entry_t head,
    input  logic                  empty,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  beat_seen,
    output logic                  rate_update,
    output logic [31:0]           beat_interval_ms,
    output logic [15:0]           tempo_bpm
);
    import gte_pkg::*;

    localparam int ADDR_W = $clog2(SAMPLE_COUNT);
    localparam int SUM_W = 32 + $clog2(SAMPLE_COUNT);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(SAMPLE_COUNT - 1);

    // The mean is the trimmed sum times a rounded-up reciprocal of SAMPLE_COUNT - 2,
    // which is exact for every sum that fits in SUM_W bits.
    localparam int DIV_L = $clog2(SAMPLE_COUNT - 2);
    localparam int RECIP_SHIFT = SUM_W + DIV_L;
    localparam int RECIP_W = SUM_W + 1;
    localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(((64'd1 << RECIP_SHIFT)
        + 64'(SAMPLE_COUNT - 3)) / 64'(SAMPLE_COUNT - 2));
    localparam int CHUNK_W = 16;
    localparam int MUL_CHUNKS = (SUM_W + CHUNK_W - 1) / CHUNK_W;
    localparam int MUL_X_W = MUL_CHUNKS * CHUNK_W;
    localparam int PROD_W = MUL_X_W + RECIP_W;
    localparam int MUL_CNT_W = $clog2(MUL_CHUNKS + 1);

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_SCAN      = 9'b000000010,
        ST_DRAIN     = 9'b000000100,
        ST_TRIM      = 9'b000001000,
        ST_AVG_START = 9'b000010000,
        ST_AVG_WAIT  = 9'b000100000,
        ST_CHECK     = 9'b001000000,
        ST_BPM_WAIT  = 9'b010000000,
        ST_FINISH    = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [ADDR_W-1:0] wr_ptr_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic rd_vld_reg;
    logic rd_first_reg;
    logic [31:0] max_reg;
    logic [31:0] min_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [31:0] avg_reg;
    logic [31:0] prev_avg_reg;
    logic update_reg;
    logic [15:0] bpm_reg;
    logic [MUL_X_W-1:0] mul_x_reg;
    logic [PROD_W-1:0] mul_acc_reg;
    logic [MUL_CNT_W-1:0] mul_cnt_reg;

    logic out_valid_reg;
    logic beat_seen_reg;
    logic rate_update_reg;
    logic [31:0] interval_reg;
    logic [15:0] tempo_reg;

    logic slot_free;
    logic ram_we;
    logic [31:0] rdata;
    logic [SUM_W-1:0] trimmed;
    logic [32:0] upper;
    logic [31:0] lower;
    logic update;
    logic div_start;
    logic div_done;
    logic [15:0] div_quotient;
    logic [CHUNK_W+RECIP_W-1:0] mul_part;
    logic [PROD_W-1:0] mul_acc_next;
    logic mul_last;
    logic load_simple;
    logic load_final;

    assign slot_free = !out_valid_reg || out_ready;
    assign pop = (state_reg == ST_IDLE) && !empty && (head.do_average || slot_free);
    assign ram_we = pop && head.beat_seen;
    assign load_simple = pop && !head.do_average;
    assign load_final = (state_reg == ST_FINISH) && slot_free;

    assign trimmed = sum_reg - ((max_reg == min_reg) ? '0 : SUM_W'(min_reg));
    assign upper = {1'b0, prev_avg_reg} + {17'b0, cfg.change_threshold};
    assign lower = prev_avg_reg - {16'b0, cfg.change_threshold};
    assign update = (({1'b0, avg_reg} > upper) || (avg_reg < lower)) && (avg_reg != '0);

    assign mul_part = {{RECIP_W{1'b0}}, mul_x_reg[MUL_X_W-1 -: CHUNK_W]}
        * {{CHUNK_W{1'b0}}, RECIP_M};
    assign mul_acc_next = {mul_acc_reg[PROD_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}}
        + PROD_W'(mul_part);
    assign mul_last = (mul_cnt_reg == MUL_CNT_W'(1));

    assign div_start = (state_reg == ST_CHECK) && update;

    gte_ram #(
        .WIDTH(32),
        .DEPTH(SAMPLE_COUNT)
    ) u_store (
        .clk(clk),
        .we(ram_we),
        .waddr(wr_ptr_reg),
        .wdata(head.interval),
        .re(state_reg == ST_SCAN),
        .raddr(addr_reg),
        .rdata(rdata)
    );

    gte_div #(
        .WIDTH(16)
    ) u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .dividend(BPM_NUMERATOR[15:0]),
        .divisor(avg_reg),
        .done(div_done),
        .quotient(div_quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop && head.do_average)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_TRIM;
            end
            ST_TRIM:
            begin
                state_next = ST_AVG_START;
            end
            ST_AVG_START:
            begin
                state_next = ST_AVG_WAIT;
            end
            ST_AVG_WAIT:
            begin
                if (mul_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = update ? ST_BPM_WAIT : ST_FINISH;
            end
            ST_BPM_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            addr_reg <= '0;
        end
        else if (state_reg == ST_SCAN)
        begin
            addr_reg <= addr_reg + 1'b1;
        end
        rd_first_reg <= (addr_reg == '0);

        if (rd_vld_reg)
        begin
            if (rd_first_reg)
            begin
                max_reg <= rdata;
                min_reg <= rdata;
                sum_reg <= SUM_W'(rdata);
            end
            else
            begin
                if (rdata > max_reg)
                begin
                    max_reg <= rdata;
                end
                if (rdata < min_reg)
                begin
                    min_reg <= rdata;
                end
                sum_reg <= sum_reg + SUM_W'(rdata);
            end
        end
        else if (state_reg == ST_TRIM)
        begin
            sum_reg <= sum_reg - SUM_W'(max_reg);
        end

        if (state_reg == ST_AVG_START)
        begin
            mul_x_reg <= MUL_X_W'(trimmed);
            mul_acc_reg <= '0;
            mul_cnt_reg <= MUL_CNT_W'(MUL_CHUNKS);
        end
        else if (state_reg == ST_AVG_WAIT)
        begin
            mul_x_reg <= {mul_x_reg[MUL_X_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
            mul_acc_reg <= mul_acc_next;
            mul_cnt_reg <= mul_cnt_reg - 1'b1;
        end

        if ((state_reg == ST_AVG_WAIT) && mul_last)
        begin
            avg_reg <= mul_acc_next[RECIP_SHIFT +: 32];
        end
        if (state_reg == ST_CHECK)
        begin
            update_reg <= update;
        end
        if ((state_reg == ST_BPM_WAIT) && div_done)
        begin
            bpm_reg <= div_quotient;
        end

        if (load_simple)
        begin
            beat_seen_reg <= head.beat_seen;
            rate_update_reg <= 1'b0;
            interval_reg <= '0;
            tempo_reg <= '0;
        end
        else if (load_final)
        begin
            beat_seen_reg <= 1'b1;
            rate_update_reg <= update_reg;
            interval_reg <= update_reg ? avg_reg : '0;
            tempo_reg <= update_reg ? bpm_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wr_ptr_reg <= '0;
            rd_vld_reg <= 1'b0;
            prev_avg_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_vld_reg <= (state_reg == ST_SCAN);
            if (ram_we)
            begin
                wr_ptr_reg <= head.do_average ? '0 : wr_ptr_reg + 1'b1;
            end
            if (state_reg == ST_CHECK)
            begin
                prev_avg_reg <= avg_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (load_simple || load_final)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign beat_seen = beat_seen_reg;
    assign rate_update = rate_update_reg;
    assign beat_interval_ms = interval_reg;
    assign tempo_bpm = tempo_reg;

endmodule

/* rtl/gesture_tempo_estimator_top.sv */
// Gesture tempo estimator, top level; depends on gte_pkg, gte_front, gte_queue,
// gte_back and the assertion macros in gesture_tempo_estimator_top_defines.svh.
// Frames enter on in_valid/in_ready with hand_y, time_ms and active; every request
// yields exactly one result on out_valid/out_ready, in order. Inactive frames and
// frames without a reversal give an all-zero result; a reversal sets beat_seen.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; write it only while the block is idle. Unknown indexes are ignored.
// A frame that does not complete a set of intervals is registered in the queue
// and the output register; such frames pass at one per cycle while the back end
// is idle and the receiver is ready. The frame that completes a set makes one
// pass over the interval RAM at one word a cycle, a three-step multiply by the
// reciprocal of SAMPLE_COUNT - 2 for the mean and, for a new tempo, a serial
// divide of 16 quotient bits. Later frames wait meanwhile in a four-entry queue.
// Reset clears the tracking state and the previous average and loads the register
// defaults; the interval RAM needs no clearing. When the receiver stalls, the
// result is held, the queue fills, and in_ready drops once it is full.
module gesture_tempo_estimator_top #(
    parameter int SAMPLE_COUNT = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [15:0]                   hand_y,
    input  logic [31:0]                          time_ms,
    input  logic                                 active,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 beat_seen,
    output logic                                 rate_update,
    output logic [31:0]                          beat_interval_ms,
    output logic [15:0]                          tempo_bpm,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [gte_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [gte_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import gte_pkg::*;

    `include "gesture_tempo_estimator_top_defines.svh"

    cfg_t cfg_reg;
    logic push;
    logic pop;
    logic queue_full;
    logic queue_empty;
    queue_entry_t push_entry;
    queue_entry_t head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.change_threshold <= CHANGE_THRESHOLD_RESET;
            cfg_reg.motion_deadband <= MOTION_DEADBAND_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CHANGE_THRESHOLD:
                begin
                    cfg_reg.change_threshold <= cfg_data;
                end
                CFG_MOTION_DEADBAND:
                begin
                    cfg_reg.motion_deadband <= cfg_data[7:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    gte_front #(
        .SAMPLE_COUNT(SAMPLE_COUNT)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_reg),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .hand_y(hand_y),
        .time_ms(time_ms),
        .active(active),
        .queue_full(queue_full),
        .push(push),
        .push_entry(push_entry)
    );

    gte_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .push_entry(push_entry),
        .pop(pop),
        .head(head),
        .full(queue_full),
        .empty(queue_empty)
    );

    gte_back #(
        .SAMPLE_COUNT(SAMPLE_COUNT)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_reg),
        .head(head),
        .empty(queue_empty),
        .pop(pop),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .beat_seen(beat_seen),
        .rate_update(rate_update),
        .beat_interval_ms(beat_interval_ms),
        .tempo_bpm(tempo_bpm)
    );

    `GTE_ASSERT_NOW(a_update_needs_beat, clk, rst_n, out_valid && rate_update, beat_seen)
    `GTE_ASSERT_NOW(a_update_nonzero, clk, rst_n, out_valid && rate_update,
        beat_interval_ms != 32'd0)
    `GTE_ASSERT_NOW(a_quiet_result_zero, clk, rst_n, out_valid && !rate_update,
        beat_interval_ms == 32'd0 && tempo_bpm == 16'd0)
    `GTE_ASSERT_NEXT(a_result_held, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(beat_interval_ms) && $stable(tempo_bpm))

endmodule
